// ===== rtl/gbfs_pkg.sv =====
// Shared types and constants for the grid breadth-first distance map.
// Used by gbfs_col and grid_bfs_distance_map; depends on nothing else.
package gbfs_pkg;

    localparam int GRID_MAX = 32;
    localparam int ROW_W    = 5;
    localparam int SIZE_W   = 6;
    localparam int DIST_W   = 11;
    localparam int FUNC_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    typedef logic [GRID_MAX-1:0] t_rows;

    // Operation broadcast to every column cell.
    typedef struct packed {
        logic wr;    // write one blocked mark
        logic snap;  // copy blocked marks into the search snapshot
        logic seed;  // load the source into the frontier
        logic step;  // advance the frontier by one level
    } t_cell_ctrl;

endpackage

// ===== rtl/gbfs_col.sv =====
// One column cell of the grid: blocked marks, search snapshot, visited and frontier bits.
// Depends on gbfs_pkg; exchanges its frontier with the neighboring columns every step.
module gbfs_col (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gbfs_pkg::t_cell_ctrl i_ctrl,
    input  gbfs_pkg::t_rows      i_sel_rows,
    input  logic                 i_blocked_value,
    input  gbfs_pkg::t_rows      i_row_mask,
    input  gbfs_pkg::t_rows      i_front_left,
    input  gbfs_pkg::t_rows      i_front_right,
    output gbfs_pkg::t_rows      o_front,
    output gbfs_pkg::t_rows      o_visited
);
    import gbfs_pkg::*;

    t_rows r_blk, r_snap, r_vis, r_front;
    t_rows n_blk, n_snap, n_vis, n_front;
    t_rows w_reach;

    // Rows reachable in one move: vertical within the column, horizontal from neighbors.
    assign w_reach = ((r_front << 1) | (r_front >> 1) | i_front_left | i_front_right)
                     & ~r_vis & ~r_snap & i_row_mask;

    always_comb begin
        n_blk   = r_blk;
        n_snap  = r_snap;
        n_vis   = r_vis;
        n_front = r_front;
        if (i_ctrl.wr) begin
            n_blk = (r_blk & ~i_sel_rows) | (i_sel_rows & {GRID_MAX{i_blocked_value}});
        end
        if (i_ctrl.snap) begin
            n_snap = r_blk;
        end
        if (i_ctrl.seed) begin
            n_vis   = i_sel_rows;
            n_front = i_sel_rows;
        end else if (i_ctrl.step) begin
            n_vis   = r_vis | w_reach;
            n_front = w_reach;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk   <= '0;
            r_snap  <= '0;
            r_vis   <= '0;
            r_front <= '0;
        end else begin
            r_blk   <= n_blk;
            r_snap  <= n_snap;
            r_vis   <= n_vis;
            r_front <= n_front;
        end
    end

    assign o_front   = r_front;
    assign o_visited = r_vis;

endmodule

// ===== rtl/grid_bfs_distance_map.sv =====
// Top level of the grid breadth-first distance map.
// Depends on gbfs_pkg and instantiates one gbfs_col per grid column.
//
// Usage: a transaction is accepted at a rising edge where start is high and
// busy is low. Every transaction produces exactly one result, shown on
// o_distance and o_coord_valid for one cycle while o_done is high; the
// receiver cannot hold it off and needs no handshake back.
// For a blocked-mark write, a search, a read before any search, an
// out-of-grid coordinate or an unused function, the result appears the
// cycle after acceptance and busy never rises. A search only snapshots the
// blocked marks and records the source and grid size. A distance read
// replays the search on the row of column cells, one breadth-first level
// per cycle, until the target cell is reached or the frontier dies out;
// busy is high for the whole replay.
// The grid size register is written through i_cfg_we / i_cfg_wdata while
// the block is idle: the user must keep to this, since the block itself
// leaves it unchecked. Reset clears all blocked marks, forgets any search
// (so every read returns -1) and sets the grid size to 32.
module grid_bfs_distance_map (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [gbfs_pkg::FUNC_W-1:0]  i_func,
    input  logic [gbfs_pkg::ROW_W-1:0]   i_cell_row,
    input  logic [gbfs_pkg::ROW_W-1:0]   i_cell_col,
    input  logic                         i_blocked_value,
    input  logic                         i_cfg_we,
    input  logic [gbfs_pkg::SIZE_W-1:0]  i_cfg_wdata,
    output logic                         o_done,
    output logic signed [gbfs_pkg::DIST_W-1:0] o_distance,
    output logic                         o_coord_valid
);
    import gbfs_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              r_state, n_state;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] r_snap_size;
    logic              r_searched;
    logic [ROW_W-1:0]  r_src_row, r_src_col;
    logic [ROW_W-1:0]  r_tgt_row, r_tgt_col;
    logic [DIST_W-1:0] r_level;
    logic              r_done;
    logic [DIST_W-1:0] r_dist;
    logic              r_cv;

    logic       w_accept;
    logic       w_ok;
    logic       w_replay;
    t_cell_ctrl w_ctrl;
    t_rows      w_row_mask;
    t_rows      w_onehot_src;
    t_rows      w_onehot_in;
    logic       w_any_front;
    logic       w_hit;
    t_rows      w_front [GRID_MAX];
    t_rows      w_vis   [GRID_MAX];

    assign w_accept = start && !busy;
    assign w_ok = ({1'b0, i_cell_row} < r_size) && ({1'b0, i_cell_col} < r_size);
    assign w_replay = w_accept && (i_func == FUNC_READ) && w_ok && r_searched;

    // Rows inside the grid that the last search used.
    always_comb begin
        for (int i = 0; i < GRID_MAX; i++) begin
            w_row_mask[i] = (SIZE_W'(i) < r_snap_size);
        end
    end

    assign w_onehot_src = t_rows'(1) << r_src_row;
    assign w_onehot_in  = t_rows'(1) << i_cell_row;

    always_comb begin
        w_ctrl.wr   = w_accept && (i_func == FUNC_WRITE) && w_ok;
        w_ctrl.snap = w_accept && (i_func == FUNC_SEARCH) && w_ok;
        w_ctrl.seed = w_replay;
        w_ctrl.step = (r_state == ST_RUN);
    end

    genvar g;
    generate
        for (g = 0; g < GRID_MAX; g++) begin : g_col
            t_rows w_sel;
            t_rows w_left, w_right;
            logic  w_col_in;

            assign w_col_in = (SIZE_W'(g) < r_snap_size);
            // Write selects the input cell; seeding selects the stored source.
            assign w_sel = w_ctrl.wr
                           ? ((i_cell_col == ROW_W'(g)) ? w_onehot_in : '0)
                           : ((r_src_col == ROW_W'(g)) ? w_onehot_src : '0);
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_front[g-1];
            end
            if (g == GRID_MAX - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_front[g+1];
            end

            gbfs_col u_col (
                .i_clk           (i_clk),
                .i_rst_n         (i_rst_n),
                .i_ctrl          (w_ctrl),
                .i_sel_rows      (w_sel),
                .i_blocked_value (i_blocked_value),
                .i_row_mask      (w_row_mask & {GRID_MAX{w_col_in}}),
                .i_front_left    (w_left),
                .i_front_right   (w_right),
                .o_front         (w_front[g]),
                .o_visited       (w_vis[g])
            );
        end
    endgenerate

    always_comb begin
        w_any_front = 1'b0;
        for (int i = 0; i < GRID_MAX; i++) begin
            w_any_front = w_any_front | (|w_front[i]);
        end
    end

    assign w_hit = w_vis[r_tgt_col][r_tgt_row];

    // While replaying, the target is checked before each step; r_level counts
    // the levels already expanded, which is the target's distance on a hit.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_replay) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_hit || !w_any_front) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= SIZE_W'(GRID_MAX);
            r_snap_size <= SIZE_W'(GRID_MAX);
            r_searched  <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (w_ctrl.snap) begin
                r_searched  <= 1'b1;
                r_snap_size <= r_size;
            end
            r_done <= (w_accept && !w_replay)
                      || ((r_state == ST_RUN) && (w_hit || !w_any_front));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.snap) begin
            r_src_row <= i_cell_row;
            r_src_col <= i_cell_col;
        end
        if (w_replay) begin
            r_tgt_row <= i_cell_row;
            r_tgt_col <= i_cell_col;
            r_level   <= '0;
        end else if (r_state == ST_RUN) begin
            r_level <= r_level + DIST_W'(1);
        end
        if (w_accept) begin
            r_cv <= w_ok;
            if (i_func == FUNC_READ) begin
                r_dist <= DIST_NONE;
            end else begin
                r_dist <= '0;
            end
        end else if (r_state == ST_RUN) begin
            r_dist <= w_hit ? r_level : DIST_NONE;
        end
    end

    assign busy          = (r_state == ST_RUN);
    assign o_done        = r_done;
    assign o_distance    = r_dist;
    assign o_coord_valid = r_cv;

endmodule
